### src/tmc_pkg.sv
// Shared types and constants of the text mode console.
// Command and state encodings, field widths and blank cell values.
// No dependencies.
package tmc_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;

    localparam logic [7:0] ATTR_WHITE = 8'd15;
    localparam logic [7:0] BLANK_CHAR = 8'h20;

    localparam int QDEPTH = 2;

    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_NL    = 3'd1;
    localparam logic [2:0] MODE_BS    = 3'd2;
    localparam logic [2:0] MODE_CLR   = 3'd3;
    localparam logic [2:0] MODE_SET   = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NL,
        OP_BS,
        OP_CLR,
        OP_SET,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [7:0]       char_code;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_ADDR,
        ST_MEM,
        ST_SCROLL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        FILL_INIT,
        FILL_CLEAR,
        FILL_SCROLL
    } t_fill;

endpackage

### src/tmc_front.sv
// Front end of the text mode console: takes requests, decodes the mode and
// clamps col and row, and holds one decoded command for the queue.
// Depends on tmc_pkg.
module tmc_front import tmc_pkg::*; #(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_col,
    input  logic [4:0] i_row,
    input  logic       i_init_busy,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = i_init_busy || (r_vld && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && !i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        case (i_mode)
            MODE_PUT:  n_cmd.op = OP_PUT;
            MODE_NL:   n_cmd.op = OP_NL;
            MODE_BS:   n_cmd.op = OP_BS;
            MODE_CLR:  n_cmd.op = OP_CLR;
            MODE_SET:  n_cmd.op = OP_SET;
            MODE_READ: n_cmd.op = OP_READ;
            default:   n_cmd.op = OP_NOP;
        endcase
        n_cmd.char_code = i_char_code;
        n_cmd.col = (COL_W'(i_col) > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(i_col);
        n_cmd.row = (ROW_W'(i_row) > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(i_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### src/tmc_queue.sv
// Short command queue between the front end and the back end.
// Depends on tmc_pkg.
module tmc_queue import tmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_din,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_dout,
    output logic o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

### src/tmc_back.sv
// Back end of the text mode console: screen store, cursor, row ring offset,
// fill sweeps for reset, clear and scroll, and the result register.
// Depends on tmc_pkg.
module tmc_back import tmc_pkg::*; #(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_pop,
    output logic       o_init_busy,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    logic [15:0]       mem [CELLS];
    logic [15:0]       r_rdq;

    t_state            r_state;
    t_state            n_state;
    t_fill             r_kind;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_top;
    logic              r_out_valid;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic [7:0]        r_out_char;
    logic [7:0]        r_out_attr;

    logic              out_free;
    logic              mem_we;
    logic [15:0]       mem_wdata;
    logic              load_out;
    logic              col_last;
    logic              row_last;
    logic              at_home;
    logic              fill_last;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  prev_col;
    logic [ROW_W-1:0]  prev_row;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  prow;
    logic [ADDR_W-1:0] phys_addr;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign col_last    = (r_col == COL_W'(COLS - 1));
    assign row_last    = (r_row == ROW_W'(ROWS - 1));
    assign at_home     = (r_col == '0) && (r_row == '0);
    assign fill_last   = (r_cnt == CNT_W'(1));
    assign prev_col    = (r_col == '0) ? COL_W'(COLS - 1) : r_col - 1'b1;
    assign prev_row    = (r_col == '0) ? r_row - 1'b1 : r_row;
    assign o_init_busy = (r_state == ST_FILL) && (r_kind == FILL_INIT);

    always_comb begin
        a_col = r_col;
        a_row = r_row;
        if (r_state == ST_SCROLL) begin
            a_col = '0;
            a_row = '0;
        end else begin
            case (r_cmd.op)
                OP_BS: begin
                    a_col = prev_col;
                    a_row = prev_row;
                end
                OP_READ: begin
                    a_col = r_cmd.col;
                    a_row = r_cmd.row;
                end
                default: begin
                    a_col = r_col;
                    a_row = r_row;
                end
            endcase
        end
        row_sum   = {1'b0, a_row} + {1'b0, r_top};
        prow      = (row_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                                    : ROW_W'(row_sum);
        phys_addr = ADDR_W'(int'(prow) * COLS + int'(a_col));
    end

    always_comb begin
        case (r_state)
            ST_FILL: begin
                if (fill_last) begin
                    n_state = (r_kind == FILL_INIT) ? ST_IDLE : ST_DONE;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_IDLE: begin
                n_state = (!i_q_empty && out_free) ? ST_ADDR : ST_IDLE;
            end
            ST_ADDR: begin
                case (r_cmd.op)
                    OP_PUT:  n_state = ST_MEM;
                    OP_READ: n_state = ST_MEM;
                    OP_BS:   n_state = at_home ? ST_DONE : ST_MEM;
                    OP_NL:   n_state = row_last ? ST_SCROLL : ST_DONE;
                    OP_CLR:  n_state = ST_FILL;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_MEM: begin
                n_state = ((r_cmd.op == OP_PUT) && col_last && row_last) ? ST_SCROLL : ST_DONE;
            end
            ST_SCROLL: n_state = ST_FILL;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == ST_IDLE) && !i_q_empty && out_free;
        mem_we    = (r_state == ST_FILL) ||
                    ((r_state == ST_MEM) && ((r_cmd.op == OP_PUT) || (r_cmd.op == OP_BS)));
        mem_wdata = ((r_state == ST_MEM) && (r_cmd.op == OP_PUT)) ? {ATTR_WHITE, r_cmd.char_code}
                                                                  : {ATTR_WHITE, BLANK_CHAR};
        load_out  = (r_state == ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rdq <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_kind      <= FILL_INIT;
            r_addr      <= '0;
            r_cnt       <= CNT_W'(CELLS);
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_FILL: begin
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (fill_last) begin
                        r_col <= '0;
                        if (r_kind == FILL_SCROLL) begin
                            r_row <= ROW_W'(ROWS - 1);
                            r_top <= (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
                        end else begin
                            r_row <= '0;
                            r_top <= '0;
                        end
                    end
                end
                ST_ADDR: begin
                    r_addr <= (r_cmd.op == OP_CLR) ? '0 : phys_addr;
                    case (r_cmd.op)
                        OP_BS: begin
                            if (!at_home) begin
                                r_col <= prev_col;
                                r_row <= prev_row;
                            end
                        end
                        OP_NL: begin
                            if (!row_last) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end
                        end
                        OP_SET: begin
                            r_col <= r_cmd.col;
                            r_row <= r_cmd.row;
                        end
                        OP_CLR: begin
                            r_cnt  <= CNT_W'(CELLS);
                            r_kind <= FILL_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_MEM: begin
                    if ((r_cmd.op == OP_PUT) && !(col_last && row_last)) begin
                        if (col_last) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_SCROLL: begin
                    r_addr <= phys_addr;
                    r_cnt  <= CNT_W'(COLS);
                    r_kind <= FILL_SCROLL;
                end
                default: begin
                end
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_out_col  <= 7'(r_col);
            r_out_row  <= 5'(r_row);
            r_out_char <= (r_cmd.op == OP_READ) ? r_rdq[7:0] : 8'd0;
            r_out_attr <= (r_cmd.op == OP_READ) ? r_rdq[15:8] : 8'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

### src/text_mode_console.sv
// Top level of the text mode console: front end, command queue, back end.
// Depends on tmc_pkg, tmc_front, tmc_queue and tmc_back.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_mode, i_char_code, i_col, i_row
//  result    out        o_out_valid / i_out_stall o_cursor_col, o_cursor_row,
//                                                 o_cell_char, o_cell_attr
//
// Put, read and backspace off home step through the address, memory and done
// states; newline, set, no-op and backspace at home skip the memory state.
// Clear sweeps every cell of the screen store; a scroll adds a sweep of one row,
// as the port of the screen store takes one write per cycle.
// After reset a blanking pass over the screen store holds o_in_stall high.
// Up to three requests are buffered ahead of the back end; the result
// register holds while i_out_stall is high.
module text_mode_console import tmc_pkg::*; #(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_col,
    input  logic [4:0] i_row,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic init_busy;

    tmc_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    tmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_dout  (q_cmd),
        .o_empty (q_empty)
    );

    tmc_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_cmd),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_init_busy  (init_busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

### src/tmc_checker.sv
// Port-level checks of the text mode console, bound to the top level.
// Depends on tmc_pkg and text_mode_console.
module tmc_checker import tmc_pkg::*; #(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_mode,
    input logic [7:0] i_char_code,
    input logic [6:0] i_col,
    input logic [4:0] i_row,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_cursor_col,
    input logic [4:0] o_cursor_row,
    input logic [7:0] o_cell_char,
    input logic [7:0] o_cell_attr
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("result or request taken right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_col)
            && $stable(o_cursor_row) && $stable(o_cell_char) && $stable(o_cell_attr))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_cursor_col) < COLS) && (int'(o_cursor_row) < ROWS))
        else $error("cursor out of range");

    a_cell_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cell_attr == 8'd15) || (o_cell_attr == 8'd0 && o_cell_char == 8'd0))
        else $error("cell read inconsistent");

endmodule

bind text_mode_console tmc_checker #(.COLS(COLS), .ROWS(ROWS)) u_tmc_checker (.*);
